>>> sv/kvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  // Widest key and value the ports carry, in bytes
  localparam int unsigned KEY_MAX_BYTES = 20;
  localparam int unsigned VAL_MAX_BYTES = 11;
  localparam int unsigned STR_W         = 8 * KEY_MAX_BYTES;
  localparam int unsigned VAL_PORT_W    = 8 * VAL_MAX_BYTES;
  localparam int unsigned POS_W         = 8;

  typedef enum logic [2:0] {
    KIND_SEARCH = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_UPDATE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // C-string cleanup: the first zero byte, all bytes after it and all bytes
  // at or beyond nbytes read as zero.
  function automatic logic [STR_W-1:0] canon_str(input logic [STR_W-1:0] raw,
                                                 input int unsigned nbytes);
    logic [STR_W-1:0] res;
    logic             live;
    res  = '0;
    live = 1'b1;
    for (int b = 0; b < int'(KEY_MAX_BYTES); b++) begin
      live = live && (b < int'(nbytes)) && (raw[b*8 +: 8] != 8'h00);
      if (live) begin
        res[b*8 +: 8] = raw[b*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/kvt_rec_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Record store: one write port, one read port, registered read data.
module kvt_rec_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 248
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/kvt_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Operation sequencer: append, clear, scan, update in place, shift-down after delete.
module kvt_seq
  import kvt_pkg::*;
#(
  parameter int unsigned ENTRIES = 128,
  parameter int unsigned KW      = 160,
  parameter int unsigned VW      = 88,
  localparam int unsigned AW     = $clog2(ENTRIES),
  localparam int unsigned CW     = $clog2(ENTRIES + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2:0]         kind_i,
  input  wire logic [KW-1:0]      key_i,
  input  wire logic [VW-1:0]      val_i,
  output logic                    busy_o,
  output logic                    done_o,
  output status_e                 status_o,
  output logic [POS_W-1:0]        pos_o,
  output logic [VW-1:0]           fval_o,
  output logic [CW-1:0]           cnt_o,
  output logic                    we_o,
  output logic [AW-1:0]           waddr_o,
  output logic [KW+VW-1:0]        wdata_o,
  output logic [AW-1:0]           raddr_o,
  input  wire logic [KW+VW-1:0]   rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    cmp_q, cmp_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [VW-1:0]    fval_q, fval_d;

  kind_e            kind_q;
  logic [KW-1:0]    key_q;
  logic [VW-1:0]    val_q;

  logic [CW-1:0]    cmp_ext;
  logic [CW-1:0]    pos_hit;
  logic             key_hit;
  kind_e            kind_in;

  assign kind_in = kind_e'(kind_i);
  assign cmp_ext = CW'(cmp_q);
  assign pos_hit = cmp_ext + CW'(1);
  assign key_hit = (rdata_i[KW+VW-1:VW] == key_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmp_d    = cmp_q;
    done_d   = 1'b0;
    status_d = status_q;
    pos_d    = pos_q;
    fval_d   = fval_q;
    we_o     = 1'b0;
    waddr_o  = cmp_q;
    wdata_o  = {key_q, val_q};
    raddr_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          done_d   = 1'b1;
          status_d = ST_DONE;
          pos_d    = '0;
          fval_d   = '0;
          cmp_d    = '0;
          unique case (kind_in)
            KIND_SEARCH, KIND_DELETE, KIND_UPDATE: begin
              if (cnt_q == '0) begin
                status_d = ST_NOT_FOUND;
              end else begin
                done_d  = 1'b0;
                state_d = S_SCAN;
              end
            end
            KIND_APPEND: begin
              if (cnt_q >= CW'(ENTRIES)) begin
                status_d = ST_FULL;
              end else begin
                we_o    = 1'b1;
                waddr_o = cnt_q[AW-1:0];
                wdata_o = {key_i, val_i};
                cnt_d   = cnt_q + CW'(1);
                pos_d   = POS_W'(cnt_q + CW'(1));
              end
            end
            KIND_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        raddr_o = cmp_q + AW'(1);
        if (key_hit) begin
          done_d   = 1'b1;
          status_d = ST_DONE;
          pos_d    = POS_W'(pos_hit);
          fval_d   = rdata_i[VW-1:0];
          state_d  = S_IDLE;
          if (kind_q == KIND_UPDATE) begin
            we_o    = 1'b1;
            wdata_o = {key_q, val_q};
            fval_d  = val_q;
          end else if (kind_q == KIND_DELETE) begin
            cnt_d = cnt_q - CW'(1);
            // later records present: move them down one place
            if (pos_hit < cnt_q) begin
              state_d = S_SHIFT;
            end
          end
        end else if (pos_hit == cnt_q) begin
          done_d   = 1'b1;
          status_d = ST_NOT_FOUND;
          pos_d    = '0;
          fval_d   = '0;
          state_d  = S_IDLE;
        end else begin
          cmp_d = cmp_q + AW'(1);
        end
      end

      S_SHIFT: begin
        // rdata holds record cmp+1; next read fetches cmp+2
        raddr_o = cmp_q + AW'(2);
        we_o    = 1'b1;
        wdata_o = rdata_i;
        if (pos_hit < cnt_q) begin
          cmp_d = cmp_q + AW'(1);
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      cmp_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
      pos_q    <= '0;
      fval_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      cmp_q    <= cmp_d;
      done_q   <= done_d;
      status_q <= status_d;
      pos_q    <= pos_d;
      fval_q   <= fval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      kind_q <= kind_in;
      key_q  <= key_i;
      val_q  <= val_i;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign pos_o    = pos_q;
  assign fval_o   = fval_q;
  assign cnt_o    = cnt_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ENTRIES))
    else $error("record count above capacity");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (cmp_ext < cnt_q))
    else $error("scan/shift pointer beyond held records");

  a_empty_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i && kind_in == KIND_SEARCH && cnt_q == '0)
    |=> (done_q && status_q == ST_NOT_FOUND))
    else $error("search on empty table not reported as miss");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i && kind_in == KIND_APPEND && cnt_q < CW'(ENTRIES))
    |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("append did not grow the count by one");
`endif

endmodule

`default_nettype wire

>>> sv/compacting_key_value_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Append, clear, unused kinds and misses on an empty table are done without a scan; the result
// is registered. Search/update/delete scan from position 1 up: a hit reports at the first match,
// a miss after the last record held; one record per cycle through the record RAM read port.
// busy is high during the scan and, after a delete hit, while later records are moved down; no
// new transfer is taken while busy is high.
// done_o is a one-cycle strobe, no receiver stall. Reset empties the table by zeroing the count.
module compacting_key_value_table_unit
  import kvt_pkg::*;
#(
  parameter int unsigned ENTRIES     = 128,
  parameter int unsigned KEY_BYTES   = 20,
  parameter int unsigned VALUE_BYTES = 11
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  kind_i,
  input  wire logic [63:0] key_bytes_0_7_i,
  input  wire logic [63:0] key_bytes_8_15_i,
  input  wire logic [31:0] key_bytes_16_19_i,
  input  wire logic [63:0] value_bytes_0_7_i,
  input  wire logic [23:0] value_bytes_8_10_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [7:0]       position_o,
  output logic [63:0]      found_value_0_7_o,
  output logic [23:0]      found_value_8_10_o,
  output logic [7:0]       record_count_o
);

  // Stored key/value widths follow the configured byte lengths
  localparam int unsigned KW = 8 * KEY_BYTES;
  localparam int unsigned VW = 8 * VALUE_BYTES;
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [STR_W-1:0]      key_canon;
  logic [STR_W-1:0]      val_canon;
  logic [KW+VW-1:0]      rdata;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [KW+VW-1:0]      wdata;
  logic [AW-1:0]         raddr;
  logic [VW-1:0]         fval;
  logic [VAL_PORT_W-1:0] fval_full;
  logic [CW-1:0]         cnt;
  status_e               status;

  // Keys and values compare as C strings: clean them before they touch the table
  assign key_canon = canon_str({key_bytes_16_19_i, key_bytes_8_15_i, key_bytes_0_7_i},
                               KEY_BYTES);
  assign val_canon = canon_str(STR_W'({value_bytes_8_10_i, value_bytes_0_7_i}),
                               VALUE_BYTES);

  kvt_rec_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (KW + VW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  kvt_seq #(
    .ENTRIES (ENTRIES),
    .KW      (KW),
    .VW      (VW)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (kind_i),
    .key_i    (key_canon[KW-1:0]),
    .val_i    (val_canon[VW-1:0]),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_o (status),
    .pos_o    (position_o),
    .fval_o   (fval),
    .cnt_o    (cnt),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .raddr_o  (raddr),
    .rdata_i  (rdata)
  );

  assign fval_full          = VAL_PORT_W'(fval);
  assign found_value_0_7_o  = fval_full[63:0];
  assign found_value_8_10_o = fval_full[87:64];
  assign status_o           = status;
  assign record_count_o     = POS_W'(cnt);

endmodule

`default_nettype wire

>>> tb/compacting_key_value_table_unit_tb.sv
`timescale 1ns / 1ps

module compacting_key_value_table_unit_tb;
  import kvt_pkg::*;

  // Depth of the instance under test (module default)
  localparam int TABLE_DEPTH = 128;
  localparam int KEY_W       = 160;
  localparam int VAL_W       = 88;
  localparam int POOL_SIZE   = 24;
  // Quiet cycles allowed before the run is declared hung, then the tail wait length.
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 300;
  localparam int PHASE_ITEMS = 130;

  // Kind codes the unit must treat as no-ops
  localparam logic [2:0] KIND_RSVD5 = 3'd5;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  // Random traffic mixes
  localparam int MODE_FILL  = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_DRAIN = 2;

  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_ZERO = '0;
  localparam logic [VAL_W-1:0] VAL_ONES = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] VAL_ZERO = '0;
  // "abc", terminator, then junk that must be ignored
  localparam logic [KEY_W-1:0] KEY_ABC  = {128'h1122_3344_5566_7788_99aa_bbcc_ddee_ff01,
                                           32'h0063_6261};
  localparam logic [KEY_W-1:0] KEY_ABC2 = {128'hdead_beef_0bad_f00d_cafe_1234_5678_9abc,
                                           32'h0063_6261};
  // single 0xff byte followed by junk: must not match the all-ones key
  localparam logic [KEY_W-1:0] KEY_FF1  = {144'h5a5a_5a5a_5a5a_5a5a_5a5a_5a5a_5a5a_5a5a_5a5a,
                                           8'h00, 8'hff};
  // full 20-byte key, every byte nonzero
  localparam logic [KEY_W-1:0] KEY_FULL = {8'h01, {19{8'ha5}}};
  localparam logic [VAL_W-1:0] VAL_XXY  = {56'hfe_dcba_9876_5432, 32'h0079_7878};
  localparam logic [VAL_W-1:0] VAL_SEQ  = 88'h01_0203_0405_0607_0809_0a0b;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       pos;
    logic [VAL_W-1:0] fval;
    logic [7:0]       count;
  } tbl_result_t;

  typedef struct {
    logic [2:0]       kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    bit               typed;   // want holds a hand-written expectation
    tbl_result_t      want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [2:0]  kind_i;
  logic [63:0] key_bytes_0_7_i;
  logic [63:0] key_bytes_8_15_i;
  logic [31:0] key_bytes_16_19_i;
  logic [63:0] value_bytes_0_7_i;
  logic [23:0] value_bytes_8_10_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [7:0]  position_o;
  logic [63:0] found_value_0_7_o;
  logic [23:0] found_value_8_10_o;
  logic [7:0]  record_count_o;

  compacting_key_value_table_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .kind_i             (kind_i),
    .key_bytes_0_7_i    (key_bytes_0_7_i),
    .key_bytes_8_15_i   (key_bytes_8_15_i),
    .key_bytes_16_19_i  (key_bytes_16_19_i),
    .value_bytes_0_7_i  (value_bytes_0_7_i),
    .value_bytes_8_10_i (value_bytes_8_10_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .position_o         (position_o),
    .found_value_0_7_o  (found_value_0_7_o),
    .found_value_8_10_o (found_value_8_10_o),
    .record_count_o     (record_count_o)
  );

  // ---------------------------------------------------------------------
  // Shadow table: canonical keys and values, packed at the bottom
  // ---------------------------------------------------------------------
  logic [KEY_W-1:0] shadow_key [TABLE_DEPTH];
  logic [VAL_W-1:0] shadow_val [TABLE_DEPTH];
  int               shadow_held;

  tbl_result_t pending_results[$];   // results owed by the unit, oldest first
  stim_row_t   directed_rows[$];
  int          errors;
  int          quiet_cycles;

  // Key pool so that searches, updates and deletes actually hit
  logic [KEY_W-1:0] pool_key [POOL_SIZE];
  int               pool_len [POOL_SIZE];

  // C-string view: everything from the first zero byte (or from nbytes) on
  // reads as zero.
  function automatic logic [KEY_W-1:0] cstr_trim(input logic [KEY_W-1:0] raw,
                                                 input int nbytes);
    logic [KEY_W-1:0] res;
    bit               ended;
    res   = '0;
    ended = 1'b0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (b >= nbytes || raw[b*8 +: 8] == 8'h00) ended = 1'b1;
      if (!ended) res[b*8 +: 8] = raw[b*8 +: 8];
    end
    return res;
  endfunction

  // Apply one accepted transfer to the shadow table, return what it reports
  function automatic tbl_result_t table_step(input logic [2:0] kind,
                                             input logic [KEY_W-1:0] key_raw,
                                             input logic [VAL_W-1:0] val_raw);
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] v_wide;
    logic [VAL_W-1:0] v;
    int               hit;
    tbl_result_t      r;
    k      = cstr_trim(key_raw, KEY_MAX_BYTES);
    v_wide = cstr_trim({{(KEY_W - VAL_W){1'b0}}, val_raw}, VAL_MAX_BYTES);
    v      = v_wide[VAL_W-1:0];
    r      = '0;
    r.status = ST_DONE;
    hit = -1;
    for (int i = 0; i < shadow_held; i++) begin
      if (hit < 0 && shadow_key[i] == k) hit = i;
    end
    case (kind)
      KIND_SEARCH, KIND_DELETE, KIND_UPDATE: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.pos = 8'(hit + 1);
          if (kind == KIND_UPDATE) shadow_val[hit] = v;
          r.fval = shadow_val[hit];
          if (kind == KIND_DELETE) begin
            // close the gap: later records move down one place
            for (int i = hit; i < shadow_held - 1; i++) begin
              shadow_key[i] = shadow_key[i+1];
              shadow_val[i] = shadow_val[i+1];
            end
            shadow_held--;
          end
        end
      end
      KIND_APPEND: begin
        if (shadow_held >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_key[shadow_held] = k;
          shadow_val[shadow_held] = v;
          shadow_held++;
          r.pos = 8'(shadow_held);
        end
      end
      KIND_CLEAR: begin
        shadow_held = 0;
      end
      default: begin
      end
    endcase
    r.count = 8'(shadow_held);
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] kind, input logic [KEY_W-1:0] key,
                                  input logic [VAL_W-1:0] val, input bit typed,
                                  input logic [1:0] st, input int pos,
                                  input logic [VAL_W-1:0] fv, input int cnt);
    stim_row_t row;
    row.kind        = kind;
    row.key         = key;
    row.val         = val;
    row.typed       = typed;
    row.want.status = st;
    row.want.pos    = 8'(pos);
    row.want.fval   = fv;
    row.want.count  = 8'(cnt);
    directed_rows.push_back(row);
  endfunction

  // Key from the pool (junk after the terminator half the time) or fully random
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               idx;
    if ($urandom_range(99) < 85) begin
      idx = $urandom_range(POOL_SIZE - 1);
      k   = pool_key[idx];
      if ($urandom_range(1) == 1) begin
        for (int b = pool_len[idx] + 1; b < KEY_W / 8; b++) k[b*8 +: 8] = 8'($urandom);
      end
    end else begin
      k = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    logic [95:0]      raw;
    logic [VAL_W-1:0] v;
    int               cut;
    raw = {$urandom, $urandom, $urandom};
    v   = raw[VAL_W-1:0];
    // a third of the values end early on an embedded zero byte
    if ($urandom_range(2) == 0) begin
      cut = $urandom_range(VAL_MAX_BYTES - 1);
      v[cut*8 +: 8] = 8'h00;
    end
    return v;
  endfunction

  function automatic logic [2:0] pick_kind(input int mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (roll < 80)      return KIND_APPEND;
        else if (roll < 88) return KIND_SEARCH;
        else if (roll < 94) return KIND_UPDATE;
        else                return KIND_DELETE;
      end
      MODE_DRAIN: begin
        if (roll < 12)      return KIND_APPEND;
        else if (roll < 27) return KIND_SEARCH;
        else if (roll < 35) return KIND_UPDATE;
        else                return KIND_DELETE;
      end
      default: begin
        if (roll < 30)      return KIND_APPEND;
        else if (roll < 55) return KIND_SEARCH;
        else if (roll < 70) return KIND_UPDATE;
        else if (roll < 94) return KIND_DELETE;
        else if (roll < 96) return KIND_CLEAR;
        else if (roll < 97) return KIND_RSVD5;
        else if (roll < 98) return KIND_RSVD6;
        else                return KIND_RSVD7;
      end
    endcase
  endfunction

  // One command transfer. Entered and left at a falling edge; start stays
  // high across back-to-back transfers so it is never dropped and raised in
  // the same step.
  task automatic send_cmd(input stim_row_t row, input int gap);
    tbl_result_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start              <= 1'b1;
    kind_i             <= row.kind;
    key_bytes_0_7_i    <= row.key[63:0];
    key_bytes_8_15_i   <= row.key[127:64];
    key_bytes_16_19_i  <= row.key[159:128];
    value_bytes_0_7_i  <= row.val[63:0];
    value_bytes_8_10_i <= row.val[87:64];
    // accepted at the first rising edge that sees busy low
    do @(posedge clk_i); while (busy);
    predicted = table_step(row.kind, row.key, row.val);
    pending_results.push_back(row.typed ? row.want : predicted);
    @(negedge clk_i);
  endtask

  task automatic drain_outstanding();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Result checker: each strobe retires the oldest outstanding expectation
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    tbl_result_t got;
    tbl_result_t want;
    if (rst_ni && done_o) begin
      got = {status_o, position_o, found_value_8_10_o, found_value_0_7_o, record_count_o};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.pos !== want.pos) begin
          errors++;
          $display("%0t: position expected %0d actual %0d", $time, want.pos, got.pos);
        end
        if (got.fval !== want.fval) begin
          errors++;
          $display("%0t: found value expected %h actual %h", $time, want.fval, got.fval);
        end
        if (got.count !== want.count) begin
          errors++;
          $display("%0t: record count expected %0d actual %0d", $time, want.count, got.count);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: any command transfer or result strobe counts as progress
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("compacting_key_value_table_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int        plan [10];
    int        gap;
    bit        burst;
    stim_row_t row;

    errors             = 0;
    quiet_cycles       = 0;
    shadow_held        = 0;
    rst_ni             = 1'b0;
    start              = 1'b0;
    kind_i             = KIND_SEARCH;
    key_bytes_0_7_i    = '0;
    key_bytes_8_15_i   = '0;
    key_bytes_16_19_i  = '0;
    value_bytes_0_7_i  = '0;
    value_bytes_8_10_i = '0;

    // Pool: the empty key, one full-length key, the rest of random length
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_len[p] = (p == 0) ? 0 : (p == 1) ? KEY_MAX_BYTES : $urandom_range(1, KEY_MAX_BYTES);
      pool_key[p] = '0;
      for (int b = 0; b < pool_len[p]; b++) pool_key[p][b*8 +: 8] = 8'($urandom_range(1, 255));
    end

    // Directed rows. Typed expectations only where obvious; the rest go
    // through the shadow table.
    // empty table: every lookup misses
    add_row(KIND_SEARCH, KEY_ONES, VAL_ZERO, 1, ST_NOT_FOUND, 0, VAL_ZERO, 0);
    add_row(KIND_DELETE, KEY_ONES, VAL_ZERO, 1, ST_NOT_FOUND, 0, VAL_ZERO, 0);
    add_row(KIND_UPDATE, KEY_ONES, VAL_ONES, 1, ST_NOT_FOUND, 0, VAL_ZERO, 0);
    // extremes of key and value; the all-zero key is a real key
    add_row(KIND_APPEND, KEY_ONES, VAL_ONES, 1, ST_DONE, 1, VAL_ZERO, 1);
    add_row(KIND_APPEND, KEY_ZERO, VAL_ZERO, 1, ST_DONE, 2, VAL_ZERO, 2);
    add_row(KIND_SEARCH, KEY_ZERO, VAL_ONES, 1, ST_DONE, 2, VAL_ZERO, 2);
    add_row(KIND_SEARCH, KEY_ONES, VAL_ZERO, 1, ST_DONE, 1, VAL_ONES, 2);
    // junk past the terminator must not matter
    add_row(KIND_APPEND, KEY_ABC,  VAL_XXY,  0, ST_DONE, 0, VAL_ZERO, 0);
    add_row(KIND_SEARCH, KEY_ABC2, VAL_ZERO, 0, ST_DONE, 0, VAL_ZERO, 0);
    // duplicate key: update and delete act on the first copy only
    add_row(KIND_APPEND, KEY_ONES, VAL_SEQ,  0, ST_DONE, 0, VAL_ZERO, 0);
    add_row(KIND_UPDATE, KEY_ONES, VAL_SEQ,  0, ST_DONE, 0, VAL_ZERO, 0);
    add_row(KIND_DELETE, KEY_ONES, VAL_ZERO, 0, ST_DONE, 0, VAL_ZERO, 0);
    add_row(KIND_SEARCH, KEY_ONES, VAL_ZERO, 0, ST_DONE, 0, VAL_ZERO, 0);
    // unused kinds are no-ops
    add_row(KIND_RSVD5,  KEY_ONES, VAL_ONES, 1, ST_DONE, 0, VAL_ZERO, 3);
    add_row(KIND_RSVD6,  KEY_ZERO, VAL_ONES, 1, ST_DONE, 0, VAL_ZERO, 3);
    add_row(KIND_RSVD7,  KEY_ONES, VAL_ONES, 1, ST_DONE, 0, VAL_ZERO, 3);
    // delete the first record
    add_row(KIND_DELETE, KEY_ZERO, VAL_ZERO, 0, ST_DONE, 0, VAL_ZERO, 0);
    add_row(KIND_SEARCH, KEY_FF1,  VAL_ZERO, 0, ST_DONE, 0, VAL_ZERO, 0);
    add_row(KIND_CLEAR,  KEY_ONES, VAL_ONES, 1, ST_DONE, 0, VAL_ZERO, 0);
    add_row(KIND_SEARCH, KEY_ZERO, VAL_ZERO, 1, ST_NOT_FOUND, 0, VAL_ZERO, 0);
    add_row(KIND_APPEND, KEY_FULL, VAL_ONES, 0, ST_DONE, 0, VAL_ZERO, 0);
    add_row(KIND_APPEND, KEY_ABC,  VAL_SEQ,  0, ST_DONE, 0, VAL_ZERO, 0);
    add_row(KIND_SEARCH, KEY_FULL, VAL_ZERO, 0, ST_DONE, 0, VAL_ZERO, 0);
    add_row(KIND_CLEAR,  KEY_ZERO, VAL_ZERO, 1, ST_DONE, 0, VAL_ZERO, 0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) send_cmd(directed_rows[i], $urandom_range(9));
    drain_outstanding();

    // Random part: fill to full and beyond, mix, drain to near empty, mix, refill, mix.
    // The sender waits for every result at each phase boundary.
    plan = '{MODE_FILL, MODE_FILL, MODE_FILL, MODE_MIXED, MODE_DRAIN,
             MODE_DRAIN, MODE_MIXED, MODE_FILL, MODE_FILL, MODE_MIXED};
    burst = 1'b0;
    foreach (plan[ph]) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // occasional back-to-back stretches
        if ($urandom_range(19) == 0) burst = !burst;
        gap       = burst ? 0 : $urandom_range(9);
        row.kind  = pick_kind(plan[ph]);
        row.key   = pick_key();
        row.val   = pick_value();
        row.typed = 1'b0;
        row.want  = '0;
        send_cmd(row, gap);
      end
      drain_outstanding();
    end

    // all owed results are in; give a late or stray strobe time to show
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("compacting_key_value_table_unit: match");
    end else begin
      $display("compacting_key_value_table_unit: mismatch");
    end
    $finish;
  end

endmodule
